>>> design/rle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_pkg
// Shared types and constants of the RGB Laplacian edge stream.
// ----------------------------------------------------------------------------
package rle_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam int CH_BITS   = 8;
   localparam int PIX_BITS  = 3 * CH_BITS;
   localparam int FW_BITS   = 11;
   localparam int FH_BITS   = 12;

   localparam logic [FW_BITS-1:0] FW_RESET = 11'd600;
   localparam logic [FH_BITS-1:0] FH_RESET = 12'd400;

   localparam int CSR_IDX_BITS  = 4;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_HEIGHT = 4'd1;

   localparam logic [CH_BITS-1:0] CLAMP_MAX = 8'd255;

   localparam int OUTQ_DEPTH     = 3;
   localparam int OUTQ_PTR_BITS  = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_BITS  = $clog2(OUTQ_DEPTH + 1);

   typedef struct packed {
      logic valid;
      logic pixel;
      logic emit;
      logic compute;
      logic frame_end;
   } ctl_type;

   typedef struct packed {
      logic [CH_BITS-1:0] red;
      logic [CH_BITS-1:0] green;
      logic [CH_BITS-1:0] blue;
      logic               frame_end;
   } rsp_type;

endpackage

>>> design/rle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module rle_ram #(
   parameter int DATA_W = 48,
   parameter int DEPTH  = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/rle_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_window
// Holds the two previous window columns and computes the clamped Laplacian.
// ----------------------------------------------------------------------------
module rle_window (
   input  logic                               clock,
   input  rle_pkg::ctl_type                   ctl,
   input  logic [rle_pkg::PIX_BITS-1:0]       px,
   input  logic [rle_pkg::PIX_BITS-1:0]       top,
   input  logic [rle_pkg::PIX_BITS-1:0]       mid,
   output logic                               res_valid,
   output rle_pkg::rsp_type                   res
);
   import rle_pkg::*;

   logic [PIX_BITS-1:0] win_ff [6];
   logic [CH_BITS-1:0]  edge_val [3];

   always_comb begin
      logic [10:0]        nsum;
      logic signed [11:0] diff;
      for (int c = 0; c < 3; c++) begin
         nsum = 11'(win_ff[0][c*CH_BITS +: CH_BITS]) + 11'(win_ff[3][c*CH_BITS +: CH_BITS])
              + 11'(top[c*CH_BITS +: CH_BITS])       + 11'(win_ff[1][c*CH_BITS +: CH_BITS])
              + 11'(mid[c*CH_BITS +: CH_BITS])       + 11'(win_ff[2][c*CH_BITS +: CH_BITS])
              + 11'(win_ff[5][c*CH_BITS +: CH_BITS]) + 11'(px[c*CH_BITS +: CH_BITS]);
         diff = $signed({1'b0, win_ff[4][c*CH_BITS +: CH_BITS], 3'b000}) - $signed({1'b0, nsum});
         if (diff[11]) begin
            edge_val[c] = '0;
         end else if (|diff[10:8]) begin
            edge_val[c] = CLAMP_MAX;
         end else begin
            edge_val[c] = diff[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.valid && ctl.pixel) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= px;
      end
   end

   assign res_valid     = ctl.valid && ctl.emit;
   assign res.red       = ctl.compute ? edge_val[2] : '0;
   assign res.green     = ctl.compute ? edge_val[1] : '0;
   assign res.blue      = ctl.compute ? edge_val[0] : '0;
   assign res.frame_end = ctl.frame_end;

endmodule

>>> design/rle_out_q.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_out_q
// Small result queue that decouples the window stage from the response side.
// ----------------------------------------------------------------------------
module rle_out_q (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  rle_pkg::rsp_type                    push_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rle_pkg::rsp_type                    head,
   output logic [rle_pkg::OUTQ_CNT_BITS-1:0]   count
);
   import rle_pkg::*;

   rsp_type                  q_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUTQ_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OUTQ_CNT_BITS-1:0] count_ff, count_in;
   logic                     pop;

   assign pop = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == OUTQ_PTR_BITS'(OUTQ_DEPTH - 1)) ? '0
                                                                   : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == OUTQ_PTR_BITS'(OUTQ_DEPTH - 1)) ? '0
                                                                   : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign head      = q_ff[rd_ptr_ff];
   assign count     = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (count_ff != OUTQ_CNT_BITS'(OUTQ_DEPTH)))
      else $error("result queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |=> !($past(pop)))
      else $error("result queue underflow");

endmodule

>>> design/rgb_laplacian_edge_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_laplacian_edge_stream
// 3x3 per-channel Laplacian edge filter on a raster RGB pixel stream.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports
//  req_      in         req_red, req_green, req_blue, req_flush
//  rsp_      out        rsp_out_red, rsp_out_green, rsp_out_blue, rsp_frame_end
//  csr_      in         csr_index, csr_wdata (0: frame_width, 1: frame_height)
//
//  One request per cycle is accepted while req_ready is high; each request is held
//  in stage one and its result then enters the result queue. Both line buffers share
//  one dual-port RAM: the read is issued at acceptance and the write-back happens in
//  the following cycle. A three-entry result queue absorbs response stalls;
//  req_ready drops only when the queued results plus the window-stage item fill it.
//  Reset is synchronous; the line buffers are not cleared.
// ----------------------------------------------------------------------------
module rgb_laplacian_edge_stream #(
   parameter int MAX_WIDTH  = rle_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = rle_pkg::DEF_MAX_HEIGHT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [rle_pkg::CH_BITS-1:0]        req_red,
   input  logic [rle_pkg::CH_BITS-1:0]        req_green,
   input  logic [rle_pkg::CH_BITS-1:0]        req_blue,
   input  logic                               req_flush,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [rle_pkg::CH_BITS-1:0]        rsp_out_red,
   output logic [rle_pkg::CH_BITS-1:0]        rsp_out_green,
   output logic [rle_pkg::CH_BITS-1:0]        rsp_out_blue,
   output logic                               rsp_frame_end,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rle_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [rle_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import rle_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int CW = (WW > FW_BITS) ? WW : FW_BITS;
   localparam int CH = (HW > FH_BITS) ? HW : FH_BITS;

   logic [FW_BITS-1:0]  fw_ff;
   logic [FH_BITS-1:0]  fh_ff;
   logic [WW-1:0]       w_used;
   logic [HW-1:0]       h_used;
   logic [CW-1:0]       fw_ext;
   logic [CH-1:0]       fh_ext;

   logic [XW-1:0]       col_ff, col_in;
   logic [HW-1:0]       row_ff, row_in;
   logic [WW-1:0]       drain_ff, drain_in;

   ctl_type             s1_ctl_ff, s1_ctl_in;
   logic [PIX_BITS-1:0] s1_px_ff;
   logic [XW-1:0]       s1_col_ff;

   logic                accept;
   logic                rows_pending;
   logic                cfg_hit;
   logic                ram_re;
   logic                ram_we;
   logic [2*PIX_BITS-1:0] ram_rdata;
   logic [PIX_BITS-1:0] top_px;
   logic [PIX_BITS-1:0] mid_px;
   logic [PIX_BITS-1:0] req_px;

   logic                res_valid;
   rsp_type             res;
   rsp_type             head;
   logic [OUTQ_CNT_BITS-1:0] q_count;

   assign fw_ext = CW'(fw_ff);
   assign fh_ext = CH'(fh_ff);

   always_comb begin
      if (fw_ext < CW'(3)) begin
         w_used = WW'(3);
      end else if (fw_ext > CW'(MAX_WIDTH)) begin
         w_used = WW'(MAX_WIDTH);
      end else begin
         w_used = WW'(fw_ext);
      end
      if (fh_ext < CH'(3)) begin
         h_used = HW'(3);
      end else if (fh_ext > CH'(MAX_HEIGHT)) begin
         h_used = HW'(MAX_HEIGHT);
      end else begin
         h_used = HW'(fh_ext);
      end
   end

   assign req_ready    = ({1'b0, q_count} + {{OUTQ_CNT_BITS{1'b0}}, s1_ctl_ff.valid})
                         < (OUTQ_CNT_BITS + 1)'(OUTQ_DEPTH);
   assign csr_ready    = 1'b1;
   assign accept       = req_valid && req_ready;
   assign rows_pending = (row_ff < h_used);
   assign cfg_hit      = csr_valid && csr_ready
                         && (csr_index == REG_FRAME_WIDTH || csr_index == REG_FRAME_HEIGHT);
   assign req_px       = {req_red, req_green, req_blue};

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      drain_in  = drain_ff;
      s1_ctl_in = '0;
      if (cfg_hit) begin
         col_in   = '0;
         row_in   = '0;
         drain_in = '0;
      end else if (accept) begin
         if (req_flush) begin
            if (!rows_pending) begin
               s1_ctl_in.valid = 1'b1;
               s1_ctl_in.emit  = 1'b1;
               if (drain_ff >= w_used) begin
                  s1_ctl_in.frame_end = 1'b1;
                  col_in   = '0;
                  row_in   = '0;
                  drain_in = '0;
               end else begin
                  drain_in = drain_ff + WW'(1);
               end
            end
         end else if (rows_pending) begin
            s1_ctl_in.valid   = 1'b1;
            s1_ctl_in.pixel   = 1'b1;
            s1_ctl_in.emit    = (row_ff >= HW'(2)) || (row_ff == HW'(1) && col_ff != '0);
            s1_ctl_in.compute = (row_ff >= HW'(2)) && (col_ff >= XW'(2));
            if (WW'(col_ff) + WW'(1) >= w_used) begin
               col_in = '0;
               row_in = row_ff + HW'(1);
            end else begin
               col_in = col_ff + XW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff     <= FW_RESET;
         fh_ff     <= FH_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         drain_ff  <= '0;
         s1_ctl_ff <= '0;
      end else begin
         if (csr_valid && csr_ready && csr_index == REG_FRAME_WIDTH) begin
            fw_ff <= csr_wdata[FW_BITS-1:0];
         end
         if (csr_valid && csr_ready && csr_index == REG_FRAME_HEIGHT) begin
            fh_ff <= csr_wdata[FH_BITS-1:0];
         end
         col_ff    <= col_in;
         row_ff    <= row_in;
         drain_ff  <= drain_in;
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff  <= req_px;
         s1_col_ff <= col_ff;
      end
   end

   assign ram_re = accept && !req_flush && rows_pending && !cfg_hit;
   assign ram_we = s1_ctl_ff.valid && s1_ctl_ff.pixel;
   assign top_px = ram_rdata[2*PIX_BITS-1:PIX_BITS];
   assign mid_px = ram_rdata[PIX_BITS-1:0];

   rle_ram #(
      .DATA_W (2 * PIX_BITS),
      .DEPTH  (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_col_ff),
      .wr_data ({mid_px, s1_px_ff}),
      .rd_en   (ram_re),
      .rd_addr (col_ff),
      .rd_data (ram_rdata)
   );

   rle_window u_window (
      .clock     (clock),
      .ctl       (s1_ctl_ff),
      .px        (s1_px_ff),
      .top       (top_px),
      .mid       (mid_px),
      .res_valid (res_valid),
      .res       (res)
   );

   rle_out_q u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head),
      .count     (q_count)
   );

   assign rsp_out_red   = head.red;
   assign rsp_out_green = head.green;
   assign rsp_out_blue  = head.blue;
   assign rsp_frame_end = head.frame_end;

   a_ram_no_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_re && ram_we) |-> (col_ff != s1_col_ff))
      else $error("line buffer read and write hit the same entry");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      (WW'(col_ff) < w_used))
      else $error("column counter beyond frame width");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      (row_ff <= h_used))
      else $error("row counter beyond frame height");

   a_drain_after_rows: assert property (@(posedge clock) disable iff (reset)
      (drain_ff != '0) |-> (!rows_pending && col_ff == '0))
      else $error("draining while pixels are still expected");

endmodule

>>> verif/tb_rgb_laplacian_edge_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_laplacian_edge_stream
// Self-checking testbench for the RGB Laplacian edge stream.
//
// A driver feeds pixel and flush requests from a backlog queue, and a monitor
// checks every result against an in-bench model of the 3x3 edge filter. The
// model holds its own line buffers, window, counters and frame size. The run
// starts with directed frames: reset sizes, clamped sizes, full-scale and
// zero edge values, an ignored register index, stray flushes and pixels and
// an abandoned 4095-row frame. It then goes on with random frames of random
// size and texture. Both handshakes stall at random outside a steady stretch.
// ----------------------------------------------------------------------------
module tb_rgb_laplacian_edge_stream;

   localparam int MAX_W      = rle_pkg::DEF_MAX_WIDTH;
   localparam int MAX_H      = rle_pkg::DEF_MAX_HEIGHT;
   localparam int MIN_DIM    = 3;
   localparam int IDLE_PCT   = 31;
   localparam int SETTLE_CYC = 8;
   localparam int DRAIN_CYC  = 16;
   localparam int WATCHDOG   = 4000;
   localparam int RANDOM_ITEMS = 650;
   localparam int PRINT_CAP  = 100;
   localparam logic [rle_pkg::CSR_IDX_BITS-1:0] REG_UNUSED = 4'd9;

   typedef enum int {STYLE_UNIFORM, STYLE_EXTREME, STYLE_SMOOTH, STYLE_SPARSE} pixel_style_type;

   typedef struct {
      bit                         flush;
      bit [rle_pkg::CH_BITS-1:0] red;
      bit [rle_pkg::CH_BITS-1:0] green;
      bit [rle_pkg::CH_BITS-1:0] blue;
   } stream_item_type;

   typedef bit [rle_pkg::PIX_BITS-1:0] patch_type [9];

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [rle_pkg::CH_BITS-1:0]       req_red = '0;
   logic [rle_pkg::CH_BITS-1:0]       req_green = '0;
   logic [rle_pkg::CH_BITS-1:0]       req_blue = '0;
   logic                              req_flush = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [rle_pkg::CH_BITS-1:0]       rsp_out_red;
   logic [rle_pkg::CH_BITS-1:0]       rsp_out_green;
   logic [rle_pkg::CH_BITS-1:0]       rsp_out_blue;
   logic                              rsp_frame_end;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [rle_pkg::CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [rle_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   rgb_laplacian_edge_stream dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .req_flush     (req_flush),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Edge filter model state.
   bit [rle_pkg::FW_BITS-1:0]  cfg_width;
   bit [rle_pkg::FH_BITS-1:0]  cfg_height;
   bit [rle_pkg::PIX_BITS-1:0] older_row [MAX_W];
   bit [rle_pkg::PIX_BITS-1:0] newer_row [MAX_W];
   bit [rle_pkg::PIX_BITS-1:0] window_col [6];
   int unsigned                col_pos;
   int unsigned                row_pos;
   int unsigned                drained;

   rle_pkg::rsp_type edge_expected [$];
   stream_item_type  pixel_backlog [$];
   stream_item_type  req_item;
   bit               req_done = 1'b0;
   bit               steady = 1'b0;
   int               req_queued = 0;
   int               req_taken = 0;
   int               stim_count = 0;
   int               error_count = 0;
   int               stall_cycles = 0;

   function automatic int clamp_dim(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic bit [rle_pkg::CH_BITS-1:0] laplace(input patch_type nine, input int sh);
      int acc;
      acc = 9 * int'(nine[4][sh +: 8]);
      for (int i = 0; i < 9; i++) acc -= int'(nine[i][sh +: 8]);
      if (acc > int'(rle_pkg::CLAMP_MAX)) acc = int'(rle_pkg::CLAMP_MAX);
      if (acc < 0) acc = 0;
      return acc[rle_pkg::CH_BITS-1:0];
   endfunction

   function automatic void restart_frame();
      col_pos = 0;
      row_pos = 0;
      drained = 0;
      foreach (window_col[i]) window_col[i] = '0;
   endfunction

   task automatic edge_predict(input stream_item_type it);
      int unsigned                w;
      int unsigned                h;
      int unsigned                x;
      int unsigned                y;
      bit [rle_pkg::PIX_BITS-1:0] px;
      bit [rle_pkg::PIX_BITS-1:0] top;
      bit [rle_pkg::PIX_BITS-1:0] mid;
      patch_type                  nine;
      rle_pkg::rsp_type           res;
      w = clamp_dim(int'(cfg_width), MIN_DIM, MAX_W);
      h = clamp_dim(int'(cfg_height), MIN_DIM, MAX_H);
      x = col_pos;
      y = row_pos;
      res = '0;
      if (it.flush) begin
         if (y < h) return;
         if (drained >= w) begin
            res.frame_end = 1'b1;
            restart_frame();
         end else begin
            drained++;
         end
         edge_expected.push_back(res);
         return;
      end
      if (y >= h || x >= w) return;
      px  = {it.red, it.green, it.blue};
      top = (y >= 2) ? older_row[x] : '0;
      mid = (y >= 1) ? newer_row[x] : '0;
      if (y >= 2 || (y == 1 && x >= 1)) begin
         if (x >= 2 && y >= 2) begin
            nine = '{window_col[0], window_col[3], top,
                     window_col[1], window_col[4], mid,
                     window_col[2], window_col[5], px};
            res.red   = laplace(nine, 16);
            res.green = laplace(nine, 8);
            res.blue  = laplace(nine, 0);
         end
         edge_expected.push_back(res);
      end
      window_col[0] = window_col[3];
      window_col[1] = window_col[4];
      window_col[2] = window_col[5];
      window_col[3] = top;
      window_col[4] = mid;
      window_col[5] = px;
      if (y >= 1) older_row[x] = mid;
      newer_row[x] = px;
      if (x + 1 >= w) begin
         col_pos = 0;
         row_pos = y + 1;
      end else begin
         col_pos = x + 1;
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   // Driver: presents the next request at the falling edge.
   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_done) begin
         req_done = 1'b0;
         if (pixel_backlog.size() == 0 || (!steady && $urandom_range(0, 99) < IDLE_PCT)) begin
            req_valid <= 1'b0;
         end else begin
            req_item = pixel_backlog.pop_front();
            req_valid <= 1'b1;
            req_flush <= req_item.flush;
            req_red   <= req_item.red;
            req_green <= req_item.green;
            req_blue  <= req_item.blue;
         end
      end
   end

   // Monitor: predicts on every accepted request and checks every result.
   always @(posedge clock) begin
      rle_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            edge_predict(req_item);
            req_done = 1'b1;
            req_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (edge_expected.size() == 0) begin
               report_mismatch("unexpected result, red", rsp_out_red, 0);
            end else begin
               want = edge_expected.pop_front();
               if (rsp_out_red !== want.red)
                  report_mismatch("out_red", rsp_out_red, want.red);
               if (rsp_out_green !== want.green)
                  report_mismatch("out_green", rsp_out_green, want.green);
               if (rsp_out_blue !== want.blue)
                  report_mismatch("out_blue", rsp_out_blue, want.blue);
               if (rsp_frame_end !== want.frame_end)
                  report_mismatch("frame_end", rsp_frame_end, want.frame_end);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= WATCHDOG) begin
            $display("** rgb_laplacian_edge_stream: FAILED **");
            $finish;
         end
      end
   end

   task automatic push_item(input bit flush, input bit [rle_pkg::PIX_BITS-1:0] px);
      stream_item_type it;
      it.flush = flush;
      {it.red, it.green, it.blue} = px;
      pixel_backlog.push_back(it);
      req_queued++;
   endtask

   task automatic settle();
      do @(negedge clock);
      while (req_taken != req_queued || edge_expected.size() != 0);
   endtask

   task automatic write_csr(input logic [rle_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [rle_pkg::CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock);
      while (!csr_ready);
      if (idx == rle_pkg::REG_FRAME_WIDTH) begin
         cfg_width = data[rle_pkg::FW_BITS-1:0];
         restart_frame();
      end else if (idx == rle_pkg::REG_FRAME_HEIGHT) begin
         cfg_height = data[rle_pkg::FH_BITS-1:0];
         restart_frame();
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic bit [rle_pkg::CH_BITS-1:0] pick_channel(input pixel_style_type style,
                                                              input bit [rle_pkg::CH_BITS-1:0] base);
      case (style)
         STYLE_EXTREME: return $urandom_range(0, 1) ? rle_pkg::CLAMP_MAX : 8'h00;
         STYLE_SMOOTH:  return base + 8'($urandom_range(0, 55));
         STYLE_SPARSE:  return ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00;
         default:       return 8'($urandom);
      endcase
   endfunction

   // Queues npix pixels of a w x h frame; a complete frame also gets its
   // drain flushes. Noise adds flushes that land among the pixels and
   // pixels that land in the drain, both of which the block must ignore.
   task automatic queue_frame(input int w, input int h, input pixel_style_type style,
                              input int npix, input bit noisy, input int pause_at);
      bit [rle_pkg::CH_BITS-1:0] base_r;
      bit [rle_pkg::CH_BITS-1:0] base_g;
      bit [rle_pkg::CH_BITS-1:0] base_b;
      base_r = 8'($urandom_range(0, 200));
      base_g = 8'($urandom_range(0, 200));
      base_b = 8'($urandom_range(0, 200));
      for (int i = 0; i < npix; i++) begin
         if (i == pause_at) settle();
         if (noisy && $urandom_range(0, 99) < 3) push_item(1'b1, 24'($urandom));
         push_item(1'b0, {pick_channel(style, base_r), pick_channel(style, base_g),
                          pick_channel(style, base_b)});
      end
      stim_count += npix;
      if (npix == w * h) begin
         for (int i = 0; i <= w; i++) begin
            if (noisy && $urandom_range(0, 99) < 5) push_item(1'b0, 24'($urandom));
            push_item(1'b1, 24'($urandom));
         end
         stim_count += w + 1;
      end
   endtask

   initial begin
      int              w;
      int              h;
      int              wv;
      int              hv;
      int              npix;
      bit              reconfig;
      pixel_style_type style;
      bit [rle_pkg::PIX_BITS-1:0] ring;
      bit [rle_pkg::PIX_BITS-1:0] spot;

      cfg_width  = rle_pkg::FW_RESET;
      cfg_height = rle_pkg::FH_RESET;
      restart_frame();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset size of 600 columns: a flush before any pixel is dropped, and
      // the first result appears at the second pixel of the second row.
      push_item(1'b1, '0);
      queue_frame(600, 400, STYLE_UNIFORM, 602, 1'b0, -1);
      settle();
      repeat (SETTLE_CYC) @(negedge clock);
      // An unknown register index must leave the frame in progress alone.
      write_csr(REG_UNUSED, 16'hFFFF);
      push_item(1'b0, 24'($urandom));
      settle();
      repeat (SETTLE_CYC) @(negedge clock);

      // Smallest frame; upper data bits are ignored and zero height clamps.
      write_csr(rle_pkg::REG_FRAME_WIDTH, 16'hF803);
      write_csr(rle_pkg::REG_FRAME_HEIGHT, 16'h0000);
      ring = {8'h00, 8'hFF, 8'd99};
      spot = {8'hFF, 8'h00, 8'd100};
      repeat (4) push_item(1'b0, ring);
      push_item(1'b1, '0);
      push_item(1'b0, spot);
      repeat (4) push_item(1'b0, ring);
      push_item(1'b1, '0);
      push_item(1'b0, spot);
      repeat (4) push_item(1'b1, '0);
      queue_frame(3, 3, STYLE_SMOOTH, 9, 1'b1, -1);
      settle();
      repeat (SETTLE_CYC) @(negedge clock);

      // Tallest frame, abandoned after a few rows.
      write_csr(rle_pkg::REG_FRAME_WIDTH, 16'h0001);
      write_csr(rle_pkg::REG_FRAME_HEIGHT, 16'h0FFF);
      queue_frame(3, 4095, STYLE_EXTREME, 15, 1'b0, -1);

      stim_count = 0;
      reconfig = 1'b1;
      w = 3;
      h = 4095;
      while (stim_count < RANDOM_ITEMS) begin
         steady = (stim_count >= 200 && stim_count < 450);
         if (reconfig || $urandom_range(0, 99) < 40) begin
            settle();
            repeat (SETTLE_CYC) @(negedge clock);
            if ($urandom_range(0, 99) < 10)
               write_csr(4'($urandom_range(int'(rle_pkg::REG_FRAME_HEIGHT) + 1,
                                           (1 << rle_pkg::CSR_IDX_BITS) - 1)),
                         16'($urandom));
            case ($urandom_range(0, 19))
               0:       wv = $urandom_range(0, 2);
               1, 2, 3: wv = $urandom_range(11, 48);
               default: wv = $urandom_range(3, 10);
            endcase
            hv = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
            write_csr(rle_pkg::REG_FRAME_WIDTH, {5'($urandom), 11'(wv)});
            write_csr(rle_pkg::REG_FRAME_HEIGHT, {4'($urandom), 12'(hv)});
            w = clamp_dim(wv, MIN_DIM, MAX_W);
            h = clamp_dim(hv, MIN_DIM, MAX_H);
            reconfig = 1'b0;
         end
         style = pixel_style_type'($urandom_range(0, 3));
         if ($urandom_range(0, 99) < 12) begin
            npix = $urandom_range(1, w * h - 1);
            queue_frame(w, h, style, npix, 1'b1, -1);
            reconfig = 1'b1;
         end else begin
            queue_frame(w, h, style, w * h, 1'b1,
                        ($urandom_range(0, 9) == 0) ? $urandom_range(1, w * h - 1) : -1);
         end
      end
      steady = 1'b0;

      settle();
      repeat (DRAIN_CYC) @(negedge clock);
      if (edge_expected.size() != 0)
         report_mismatch("results never delivered", 0, edge_expected.size());
      if (error_count == 0)
         $display("** rgb_laplacian_edge_stream: PASSED **");
      else
         $display("** rgb_laplacian_edge_stream: FAILED **");
      $finish;
   end

endmodule

>>> files.f
design/rle_pkg.sv
design/rle_ram.sv
design/rle_window.sv
design/rle_out_q.sv
design/rgb_laplacian_edge_stream.sv
verif/tb_rgb_laplacian_edge_stream.sv
